/* rtl/stbm_pkg.sv */
// ----------------------------------------------------------------------------
// Sorting block package
// Element type and its fixed width, shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
package stbm_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

/* rtl/stbm_in_if.sv */
// ----------------------------------------------------------------------------
// Input stream interface
// Valid/ready channel carrying one element and its last-element flag.
// ----------------------------------------------------------------------------
interface stbm_in_if import stbm_pkg::*; ();

  logic   valid;
  logic   ready;
  value_t value;
  logic   is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);

endinterface

/* rtl/stbm_out_if.sv */
// ----------------------------------------------------------------------------
// Output stream interface
// Valid/ready channel carrying one sorted element and its end-of-run flag.
// ----------------------------------------------------------------------------
interface stbm_out_if import stbm_pkg::*; ();

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_run;

  modport source (output valid, output sorted_value, output end_of_run, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, output ready);

endinterface

/* rtl/stbm_store.sv */
// ----------------------------------------------------------------------------
// Element store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module stbm_store import stbm_pkg::*; #(
  parameter int MAX_ITEMS = 64,
  localparam int AW = $clog2(MAX_ITEMS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  value_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output value_t        rdata_a,
  output value_t        rdata_b
);

  value_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds between reads so a swap can still use it in its second write.
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/stbm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sort sequencer
// Loads elements, shell-sorts both halves, runs the merge comparator
// sequence, then streams the result.
// ----------------------------------------------------------------------------
module stbm_ctrl import stbm_pkg::*; #(
  parameter int MAX_ITEMS = 64,
  localparam int AW = $clog2(MAX_ITEMS),
  localparam int CW = $clog2(MAX_ITEMS + 1),
  localparam int XW = CW + 1
) (
  input  logic              clk,
  input  logic              rst,
  stbm_in_if.sink           in_ch,
  stbm_out_if.source        out_ch,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output value_t            mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr_a,
  output logic [AW-1:0]     mem_raddr_b,
  input  value_t            mem_rdata_a,
  input  value_t            mem_rdata_b
);

  typedef enum logic [3:0] {
    LOAD, SH_INIT, SH_RD, SH_HOLD, SH_LOOP, SH_CMP, SH_NEXT, SH_END,
    MG_K, MG_J, MG_I, MG_CMP, MG_SW2, OUT_RD, OUT_LD, OUT_WAIT
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [XW-1:0]   n, p, base, len, gap, i, j, k;
  logic            seg;
  value_t          hold;
  value_t          out_value;
  logic            out_last;
  logic            out_valid;

  logic            accept, room;
  logic [XW-1:0]   n_load, seg_len, ij, ijk, jk, j_gap, i1, bi, bj, bjg;

  assign in_ch.ready         = (state == LOAD);
  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_value;
  assign out_ch.end_of_run   = out_last;

  assign accept  = in_ch.valid && (state == LOAD);
  assign room    = (count < CW'(MAX_ITEMS));
  assign n_load  = XW'(count) + XW'(room);
  assign seg_len = seg ? (n - p) : p;
  assign ij      = i + j;
  assign ijk     = ij + k;
  assign jk      = j + k;
  assign j_gap   = j - gap;
  assign i1      = i + XW'(1);
  assign bi      = base + i;
  assign bj      = base + j;
  assign bjg     = base + j_gap;

  // Store port control, decoded from the current step.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = bj[AW-1:0];
    mem_wdata   = hold;
    mem_re      = 1'b0;
    mem_raddr_a = ij[AW-1:0];
    mem_raddr_b = ijk[AW-1:0];
    unique case (state)
      LOAD: begin
        if (accept && room) begin
          mem_we    = 1'b1;
          mem_waddr = count[AW-1:0];
          mem_wdata = in_ch.value;
        end
      end
      SH_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = bi[AW-1:0];
      end
      SH_LOOP: begin
        if (j >= gap) begin
          mem_re      = 1'b1;
          mem_raddr_a = bjg[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      SH_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = (mem_rdata_a > hold) ? mem_rdata_a : hold;
      end
      MG_I: begin
        mem_re = (i < k) && (ijk < n);
      end
      MG_CMP: begin
        mem_we    = (mem_rdata_a > mem_rdata_b);
        mem_waddr = ij[AW-1:0];
        mem_wdata = mem_rdata_b;
      end
      MG_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = ijk[AW-1:0];
        mem_wdata = mem_rdata_a;
      end
      OUT_RD: begin
        mem_re      = 1'b1;
        mem_raddr_a = i[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      count     <= '0;
      seg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CW'(1);
            end
            if (in_ch.is_last) begin
              n     <= n_load;
              p     <= n_load >> 1;
              seg   <= 1'b0;
              state <= SH_INIT;
            end
          end
        end
        SH_INIT: begin
          base <= seg ? p : '0;
          len  <= seg_len;
          gap  <= seg_len >> 1;
          i    <= seg_len >> 1;
          if ((seg_len >> 1) != '0) begin
            state <= SH_RD;
          end else if (seg) begin
            state <= SH_END;
          end else begin
            seg <= 1'b1;
          end
        end
        SH_RD: begin
          state <= SH_HOLD;
        end
        SH_HOLD: begin
          hold  <= mem_rdata_a;
          j     <= i;
          state <= SH_LOOP;
        end
        SH_LOOP: begin
          // Either fetch the element one gap down or drop the held value in.
          state <= (j >= gap) ? SH_CMP : SH_NEXT;
        end
        SH_CMP: begin
          if (mem_rdata_a > hold) begin
            j     <= j_gap;
            state <= SH_LOOP;
          end else begin
            state <= SH_NEXT;
          end
        end
        SH_NEXT: begin
          if (i1 < len) begin
            i     <= i1;
            state <= SH_RD;
          end else if ((gap >> 1) != '0) begin
            gap   <= gap >> 1;
            i     <= gap >> 1;
            state <= SH_RD;
          end else if (seg) begin
            state <= SH_END;
          end else begin
            seg   <= 1'b1;
            state <= SH_INIT;
          end
        end
        SH_END: begin
          k     <= p;
          i     <= '0;
          state <= (p == '0) ? OUT_RD : MG_K;
        end
        MG_K: begin
          // The first pass starts at zero; later passes start at k.
          j     <= (k == p) ? '0 : k;
          state <= MG_J;
        end
        MG_J: begin
          if (jk <= n) begin
            i     <= '0;
            state <= MG_I;
          end else if ((k >> 1) == '0) begin
            i     <= '0;
            state <= OUT_RD;
          end else begin
            k     <= k >> 1;
            state <= MG_K;
          end
        end
        MG_I: begin
          if ((i < k) && (ijk < n)) begin
            state <= MG_CMP;
          end else begin
            j     <= j + (k << 1);
            state <= MG_J;
          end
        end
        MG_CMP: begin
          if (mem_rdata_a > mem_rdata_b) begin
            state <= MG_SW2;
          end else begin
            i     <= i1;
            state <= MG_I;
          end
        end
        MG_SW2: begin
          i     <= i1;
          state <= MG_I;
        end
        OUT_RD: begin
          state <= OUT_LD;
        end
        OUT_LD: begin
          out_value <= mem_rdata_a;
          out_last  <= (i1 == n);
          out_valid <= 1'b1;
          state     <= OUT_WAIT;
        end
        OUT_WAIT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              seg   <= 1'b0;
              state <= LOAD;
            end else begin
              i     <= i1;
              state <= OUT_RD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

/* rtl/shell_then_batcher_merge_sort.sv */
// Loading accepts one element per cycle while the input is valid. After the last
// element each shell insertion steps through SH_RD, SH_HOLD and SH_LOOP, with
// SH_CMP for each element compared one gap down, and ends in SH_NEXT; each merge
// compare steps through MG_I and MG_CMP, and MG_SW2 with a swap; each result
// steps through OUT_RD, OUT_LD and OUT_WAIT. The input is not ready from the last
// element to the last result. Reset is synchronous and active high; it empties
// the store count and idles the output, and the store itself needs no clearing.
// ----------------------------------------------------------------------------
// Shell then merge-network sorter
// Collects signed elements up to a last flag, sorts them and streams them out.
// ----------------------------------------------------------------------------
module shell_then_batcher_merge_sort import stbm_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst,
  stbm_in_if.sink     in_ch,
  stbm_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_ITEMS);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  value_t        mem_rdata_a;
  value_t        mem_rdata_b;

  stbm_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  stbm_store #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

endmodule

/* test/tb_shell_then_batcher_merge_sort.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorter testbench
// Streams runs of signed elements into the sorter, predicts the output of the
// split shell sort and the merge sequence for every run, and compares each
// emitted element and its end-of-run flag in order. Both channels idle at
// random, with one long output hold-off and an over-full store among the runs.
// ----------------------------------------------------------------------------
module tb_shell_then_batcher_merge_sort;
  import stbm_pkg::*;

  localparam int     MAX_ITEMS    = 64;
  localparam int     RANDOM_ITEMS = 270;
  localparam int     LONG_HOLD    = 400;
  localparam int     DRAIN_TAIL   = 200;
  localparam value_t VAL_MIN      = 32'h8000_0000;
  localparam value_t VAL_MAX      = 32'h7FFF_FFFF;

  typedef enum int {VALS_RANDOM, VALS_CLUSTER, VALS_EXTREME} val_mode_e;

  // Keeps the elements of the current run, sorts them the way the block does
  // on the last flag and holds the elements that are still to be emitted.
  class SortScoreboard;
    value_t held[MAX_ITEMS];
    int     held_count;
    value_t exp_value[$];
    logic   exp_last[$];
    int     errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    function void compare_swap(int lo, int hi);
      value_t t;
      if (held[lo] > held[hi]) begin
        t        = held[lo];
        held[lo] = held[hi];
        held[hi] = t;
      end
    endfunction

    function void shell_range(int base, int len);
      int     gap;
      int     i;
      int     j;
      value_t hold;
      for (gap = len >> 1; gap > 0; gap >>= 1) begin
        for (i = gap; i < len; i++) begin
          hold = held[base + i];
          j    = i;
          while (j >= gap && held[base + j - gap] > hold) begin
            held[base + j] = held[base + j - gap];
            j -= gap;
          end
          held[base + j] = hold;
        end
      end
    endfunction

    // The merge sequence is followed exactly, even where it leaves the run
    // only partly ordered.
    function void sort_held(int n);
      int p;
      int k;
      int j;
      int i;
      int lim;
      p = n >> 1;
      shell_range(0, p);
      shell_range(p, n - p);
      if (p >= 1) begin
        for (k = p; k >= 1; k >>= 1) begin
          for (j = k % p; j < n - k + 1; j += 2 * k) begin
            lim = k - 1;
            if (n - j - k - 1 < lim) lim = n - j - k - 1;
            for (i = 0; i <= lim; i++) begin
              if ((i + j) % n + k < n) compare_swap(i + j, i + j + k);
            end
          end
        end
      end
    endfunction

    function void note_input(value_t v, logic last);
      int i;
      // Elements beyond the store's capacity are dropped, but their flag counts.
      if (held_count < MAX_ITEMS) begin
        held[held_count] = v;
        held_count++;
      end
      if (last) begin
        sort_held(held_count);
        for (i = 0; i < held_count; i++) begin
          exp_value.push_back(held[i]);
          exp_last.push_back(i == held_count - 1);
        end
        held_count = 0;
      end
    endfunction

    function void check_result(value_t v, logic eor);
      value_t want_v;
      logic   want_l;
      if (exp_value.size() == 0) begin
        $error("result with nothing expected: sorted_value %0d end_of_run %0b", v, eor);
        errors++;
      end else begin
        want_v = exp_value.pop_front();
        want_l = exp_last.pop_front();
        if (v !== want_v) begin
          $error("sorted_value: expected %0d, actual %0d", want_v, v);
          errors++;
        end
        if (eor !== want_l) begin
          $error("end_of_run: expected %0b, actual %0b", want_l, eor);
          errors++;
        end
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  stbm_in_if  in_ch();
  stbm_out_if out_ch();

  shell_then_batcher_merge_sort #(.MAX_ITEMS(MAX_ITEMS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  SortScoreboard sorted_sb = new();

  bit     hold_off_req = 0;
  bit     gaps_on      = 1;
  int     burst_left   = 0;
  int     items_sent   = 0;
  value_t run_vals[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_shell_then_batcher_merge_sort NOT OK");
    $finish;
  end

  // Every emitted element is checked at the edge where it is transferred.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sorted_sb.check_result(out_ch.sorted_value, out_ch.end_of_run);
  end

  // Receiver: stalls follow a 16-bit pattern that is redrawn each time round,
  // sometimes with no stalls at all; on request it holds off for a long stretch.
  initial begin
    logic [15:0] pattern;
    int          idx;
    int          held_cycles;
    out_ch.ready <= 1'b0;
    pattern = 16'hFFFF;
    idx     = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < LONG_HOLD) begin
          @(posedge clk);
          held_cycles++;
        end
        hold_off_req = 0;
      end else begin
        out_ch.ready <= pattern[idx];
        idx = (idx + 1) % 16;
        if (idx == 0) begin
          case ($urandom_range(0, 3))
            0:       pattern = 16'hFFFF;
            1:       pattern = 16'($urandom()) & 16'($urandom());
            default: pattern = 16'($urandom()) | 16'($urandom_range(0, 1) ? 16'h5555 : 16'h0);
          endcase
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender pacing: when gaps are on, bursts of random length separated by random gaps.
  task automatic pace();
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 20);
        idle_cycles($urandom_range(1, 12));
      end
    end
  endtask

  task automatic send_element(value_t v, logic last);
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sorted_sb.note_input(v, last);
    items_sent++;
  endtask

  task automatic send_run();
    int i;
    for (i = 0; i < run_vals.size(); i++) begin
      send_element(run_vals[i], i == run_vals.size() - 1);
      pace();
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sorted_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value(val_mode_e mode);
    value_t v;
    case (mode)
      VALS_CLUSTER: v = value_t'($urandom_range(0, 8)) - 4;
      VALS_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = 0;
          3:       v = -1;
          4:       v = 1;
          default: v = value_t'($urandom());
        endcase
      end
      default: v = value_t'($urandom());
    endcase
    return v;
  endfunction

  task automatic fill_run(int len, val_mode_e mode);
    run_vals.delete();
    repeat (len) run_vals.push_back(pick_value(mode));
  endtask

  initial begin
    int        run_idx;
    int        len;
    val_mode_e mode;
    in_ch.valid   <= 1'b0;
    in_ch.value   <= '0;
    in_ch.is_last <= 1'b0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single elements at both extremes, then short runs of extremes,
    // a descending run and a run of equal values.
    run_vals = '{VAL_MIN};                                   send_run();
    run_vals = '{VAL_MAX};                                   send_run();
    run_vals = '{VAL_MAX, VAL_MIN};                          send_run();
    run_vals = '{value_t'(0), value_t'(-1), value_t'(1)};    send_run();
    run_vals = '{VAL_MAX, value_t'(7), value_t'(0), value_t'(-7), VAL_MIN};
    send_run();
    run_vals = '{value_t'(3), value_t'(3), value_t'(3), value_t'(3),
                 value_t'(3), value_t'(3), value_t'(3)};
    send_run();
    wait_drained();

    run_idx    = 0;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      mode    = val_mode_e'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (run_idx == 3)
        len = MAX_ITEMS;
      else if (run_idx == 7)
        len = MAX_ITEMS + 2;     // the last two elements are dropped, but the flag still ends the run
      else if ($urandom_range(0, 9) < 2)
        len = $urandom_range(17, 40);
      else
        len = $urandom_range(1, 12);
      // Two back-to-back runs while the receiver holds off, so the second waits at the blocked input.
      if (run_idx == 10) hold_off_req = 1;
      if (run_idx == 10 || run_idx == 11) gaps_on = 0;
      fill_run(len, mode);
      send_run();
      if (run_idx == 5 || run_idx == 12) wait_drained();
      run_idx++;
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sorted_sb.errors == 0 && sorted_sb.pending() == 0)
      $display("tb_shell_then_batcher_merge_sort OK");
    else
      $display("tb_shell_then_batcher_merge_sort NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/stbm_pkg.sv
rtl/stbm_in_if.sv
rtl/stbm_out_if.sv
rtl/stbm_store.sv
rtl/stbm_ctrl.sv
rtl/shell_then_batcher_merge_sort.sv
test/tb_shell_then_batcher_merge_sort.sv
